// ===== src/charset_table_to_utf8_decoder_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the charset decoder
// Each macro expands to one labeled concurrent assertion, clocked on clk and
// disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef CHARSET_TABLE_TO_UTF8_DECODER_MACROS_SVH
`define CHARSET_TABLE_TO_UTF8_DECODER_MACROS_SVH

// same-cycle implication
`define CTUD_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CTUD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/ctud_pkg.sv =====
// ----------------------------------------------------------------------------
// ctud_pkg
// Shared constants, types and helpers of the charset to UTF-8 decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ctud_pkg;

	localparam int NUM_MAPS    = 3;
	localparam int ENTRY_BYTES = 16;
	localparam int NUM_CODES   = 256;

	// field widths
	localparam int MAP_W  = 2;
	localparam int CODE_W = 8;
	localparam int POS_W  = 4;
	localparam int CNT_W  = 17;
	localparam int CFG_IDX_W = 1;

	localparam int ROWS    = NUM_MAPS * NUM_CODES;
	localparam int ROW_W   = $clog2(ROWS);
	localparam int ENTRY_W = ENTRY_BYTES * 8;
	localparam int LEN_W   = $clog2(ENTRY_BYTES);

	localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(4096);

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_SELECT   = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_OUT_CAPACITY = CFG_IDX_W'(1);

	// output characters
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_HYPHEN = 8'h2d;
	localparam logic [7:0] CH_QMARK  = 8'h3f;

	// device codes
	localparam logic [7:0] DEV_CR        = 8'h0d;
	localparam logic [7:0] DEV_DROP_A4   = 8'ha4;
	localparam logic [7:0] DEV_DROP_A7   = 8'ha7;
	localparam logic [7:0] DEV_DROP_8F   = 8'h8f;
	localparam logic [7:0] DEV_SPACE_81  = 8'h81;
	localparam logic [7:0] DEV_SPACE_A1  = 8'ha1;
	localparam logic [7:0] DEV_TAB_8D    = 8'h8d;
	localparam logic [7:0] DEV_TAB_A3    = 8'ha3;
	localparam logic [7:0] DEV_HYPHEN_AD = 8'had;
	localparam logic [7:0] DEV_ESC       = 8'hb0;
	localparam logic [7:0] DEV_CTRL_LO   = 8'ha1;
	localparam logic [7:0] DEV_CTRL_HI   = 8'hbf;

	typedef enum logic [1:0] {
		ESC_NORMAL,
		ESC_PENDING,
		ESC_CLOSE
	} esc_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_TWR
	} seq_state_t;

	typedef logic [ENTRY_BYTES-1:0][7:0] entry_t;

	// one run of output bytes handed to the emitter
	typedef struct packed {
		logic             valid;
		logic [LEN_W-1:0] len;
		entry_t           bytes;
	} run_t;

	function automatic logic [ROW_W-1:0] row_addr(input logic [MAP_W-1:0] m,
	                                               input logic [CODE_W-1:0] c);
		return ROW_W'(m) * ROW_W'(NUM_CODES) + ROW_W'(c);
	endfunction

	// bytes before the first zero, at most ENTRY_BYTES-1
	function automatic logic [LEN_W-1:0] entry_len(input entry_t e);
		logic [LEN_W-1:0] n;
		logic             done;
		n    = LEN_W'(ENTRY_BYTES - 1);
		done = 1'b0;
		for (int i = 0; i < ENTRY_BYTES - 1; i++) begin
			if (!done && e[i] == 8'h00) begin
				n    = LEN_W'(i);
				done = 1'b1;
			end
		end
		return n;
	endfunction

endpackage

`default_nettype wire

// ===== src/ctud_if.sv =====
// ----------------------------------------------------------------------------
// ctud channel interfaces
// Valid/ready channels for device bytes in and UTF-8 bytes out.
// ----------------------------------------------------------------------------
`default_nettype none

interface ctud_byte_if;
	logic                        valid;
	logic                        ready;
	logic                        command;
	logic [7:0]                  data_byte;
	logic                        last_byte;
	logic [ctud_pkg::MAP_W-1:0]  table_map;
	logic [ctud_pkg::CODE_W-1:0] table_code;
	logic [ctud_pkg::POS_W-1:0]  table_pos;

	modport source (
		output valid, command, data_byte, last_byte, table_map, table_code, table_pos,
		input  ready
	);
	modport sink (
		input  valid, command, data_byte, last_byte, table_map, table_code, table_pos,
		output ready
	);
endinterface

interface ctud_utf8_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       end_of_run;

	modport source (output valid, out_byte, end_of_run, input ready);
	modport sink (input valid, out_byte, end_of_run, output ready);
endinterface

`default_nettype wire

// ===== src/ctud_ram.sv =====
// ----------------------------------------------------------------------------
// ctud_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ctud_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== src/ctud_emit.sv =====
// ----------------------------------------------------------------------------
// ctud_emit
// Output stage: holds one run of up to ENTRY_BYTES-1 bytes and sends it one
// byte per transfer, flagging the last byte of the run.
// ----------------------------------------------------------------------------
`default_nettype none

module ctud_emit (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire ctud_pkg::run_t  run,
	output logic                 run_ready,
	ctud_utf8_if.source          utf8_ch
);

	logic [ctud_pkg::LEN_W-1:0] cnt_q;
	ctud_pkg::entry_t           bytes_q;
	logic                       xfer;

	assign xfer      = utf8_ch.valid && utf8_ch.ready;
	// a new run may load as the last byte of the current one leaves
	assign run_ready = (cnt_q == '0) || (cnt_q == ctud_pkg::LEN_W'(1) && utf8_ch.ready);

	assign utf8_ch.valid      = (cnt_q != '0);
	assign utf8_ch.out_byte   = bytes_q[0];
	assign utf8_ch.end_of_run = (cnt_q == ctud_pkg::LEN_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (run.valid && run_ready) begin
			cnt_q <= run.len;
		end else if (xfer) begin
			cnt_q <= cnt_q - ctud_pkg::LEN_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (run.valid && run_ready) begin
			bytes_q <= run.bytes;
		end else if (xfer) begin
			bytes_q <= {8'h00, bytes_q[ctud_pkg::ENTRY_BYTES-1:1]};
		end
	end

endmodule

`default_nettype wire

// ===== src/charset_table_to_utf8_decoder.sv =====
// ----------------------------------------------------------------------------
// charset_table_to_utf8_decoder
// Device charset to UTF-8 converter. Character tables live in one RAM row
// per code; table bytes are loaded by read-modify-write of the row.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  byte_ch   in   valid/ready    command, data_byte, last_byte, table_map,
//                                table_code, table_pos
//  utf8_ch   out  valid/ready    out_byte, end_of_run
//  cfg_*     in   cfg_we         cfg_index, cfg_data
//
// Table write: row read, then row write back; next item waits.
// Conversion with no output: done on accept. With output: row read, then
// hand-off to the output stage, which meanwhile sends 1 byte per cycle when ready.
// A run waits in the hand-off state while the output stage still holds bytes.
// Reset clears control state only; table rows are undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

`include "charset_table_to_utf8_decoder_macros.svh"

module charset_table_to_utf8_decoder (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	ctud_byte_if.sink                           byte_ch,
	ctud_utf8_if.source                         utf8_ch,
	input  wire logic                           cfg_we,
	input  wire logic [ctud_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [ctud_pkg::CNT_W-1:0]     cfg_data
);

	ctud_pkg::seq_state_t state_q, state_d;
	ctud_pkg::esc_t       esc_q;
	logic [ctud_pkg::CNT_W-1:0] bytes_written_q;
	logic                       halted_q;
	logic [ctud_pkg::MAP_W-1:0] map_select_q;
	logic [ctud_pkg::CNT_W-1:0] cap_q;

	// item held through ST_RUN or ST_TWR
	logic                       lit_q;
	logic [7:0]                 lit_byte_q;
	logic                       last_q;
	logic [ctud_pkg::ROW_W-1:0] twr_row_q;
	logic [ctud_pkg::POS_W-1:0] twr_pos_q;
	logic [7:0]                 twr_data_q;
	logic                       twr_ok_q;

	logic acc, conv_acc, tw_acc, tw_ok;
	logic [ctud_pkg::MAP_W-1:0] sel;
	logic room_one;

	// decode of a conversion byte
	logic           dec_lookup, dec_lit, dec_halt;
	logic [7:0]     dec_code, dec_lit_byte;
	ctud_pkg::esc_t dec_esc_next;

	// RAM
	logic                         ram_we, ram_re;
	logic [ctud_pkg::ROW_W-1:0]   ram_raddr;
	logic [ctud_pkg::ENTRY_W-1:0] ram_rdata, ram_wdata;
	ctud_pkg::entry_t             rd_entry, wr_entry;

	// hand-off
	logic [ctud_pkg::LEN_W-1:0] tlen;
	logic [ctud_pkg::LEN_W-1:0] run_len;
	logic                       run_valid;
	ctud_pkg::run_t             run;
	logic                       run_ready, fit, run_done;

	assign acc      = byte_ch.valid && byte_ch.ready;
	assign conv_acc = acc && !byte_ch.command;
	assign tw_acc   = acc && byte_ch.command;
	assign tw_ok    = (int'(byte_ch.table_map) < ctud_pkg::NUM_MAPS)
	               && (int'(byte_ch.table_pos) < ctud_pkg::ENTRY_BYTES);
	assign sel      = (int'(map_select_q) < ctud_pkg::NUM_MAPS) ? map_select_q : '0;
	assign room_one = ({1'b0, bytes_written_q} + (ctud_pkg::CNT_W + 1)'(1))
	                < {1'b0, cap_q};

	always_comb begin
		logic [7:0] b;
		b            = byte_ch.data_byte;
		dec_lookup   = 1'b0;
		dec_lit      = 1'b0;
		dec_halt     = 1'b0;
		dec_code     = b;
		dec_lit_byte = b;
		dec_esc_next = ctud_pkg::ESC_NORMAL;
		if (halted_q) begin
			dec_esc_next = esc_q;
		end else if (esc_q == ctud_pkg::ESC_PENDING) begin
			// escaped byte goes straight to the table
			dec_lookup   = 1'b1;
			dec_esc_next = ctud_pkg::ESC_CLOSE;
		end else if (esc_q == ctud_pkg::ESC_CLOSE && b == ctud_pkg::DEV_ESC) begin
			// closing escape swallowed
		end else if (!room_one) begin
			dec_halt = 1'b1;
		end else if (b inside {ctud_pkg::DEV_DROP_A4, ctud_pkg::DEV_DROP_A7,
		                       ctud_pkg::DEV_DROP_8F}) begin
		end else if (b == ctud_pkg::DEV_CR) begin
			dec_lit      = 1'b1;
			dec_lit_byte = ctud_pkg::CH_LF;
		end else if (b inside {ctud_pkg::DEV_SPACE_81, ctud_pkg::DEV_SPACE_A1}) begin
			dec_lookup = 1'b1;
			dec_code   = ctud_pkg::CH_SPACE;
		end else if (b inside {ctud_pkg::DEV_TAB_8D, ctud_pkg::DEV_TAB_A3}) begin
			dec_lit      = 1'b1;
			dec_lit_byte = ctud_pkg::CH_TAB;
		end else if (b == ctud_pkg::DEV_HYPHEN_AD) begin
			dec_lookup = 1'b1;
			dec_code   = ctud_pkg::CH_HYPHEN;
		end else if (b == ctud_pkg::DEV_ESC) begin
			dec_esc_next = ctud_pkg::ESC_PENDING;
		end else if (b inside {[ctud_pkg::DEV_CTRL_LO:ctud_pkg::DEV_CTRL_HI]}) begin
		end else if (b inside {ctud_pkg::CH_TAB, ctud_pkg::CH_LF}) begin
			dec_lit = 1'b1;
		end else begin
			dec_lookup = 1'b1;
		end
	end

	// run formed from the row read on accept
	assign rd_entry = ram_rdata;
	assign tlen     = ctud_pkg::entry_len(rd_entry);
	assign run_len  = (lit_q || tlen == '0) ? ctud_pkg::LEN_W'(1) : tlen;

	always_comb begin
		run.valid = run_valid;
		run.len   = run_len;
		run.bytes = '0;
		if (lit_q) begin
			run.bytes[0] = lit_byte_q;
		end else if (tlen == '0) begin
			run.bytes[0] = ctud_pkg::CH_QMARK;
		end else begin
			run.bytes = rd_entry;
		end
	end

	assign fit = ({1'b0, bytes_written_q} + (ctud_pkg::CNT_W + 1)'(run_len))
	           < {1'b0, cap_q};

	// table byte merge for the write back
	always_comb begin
		wr_entry = rd_entry;
		for (int i = 0; i < ctud_pkg::ENTRY_BYTES; i++) begin
			if (i == int'(twr_pos_q))
				wr_entry[i] = twr_data_q;
		end
	end
	assign ram_wdata = wr_entry;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ctud_pkg::ST_IDLE: begin
				if (tw_acc)
					state_d = ctud_pkg::ST_TWR;
				else if (conv_acc && (dec_lookup || dec_lit))
					state_d = ctud_pkg::ST_RUN;
			end
			ctud_pkg::ST_RUN: begin
				if (!fit || run_ready)
					state_d = ctud_pkg::ST_IDLE;
			end
			ctud_pkg::ST_TWR: begin
				state_d = ctud_pkg::ST_IDLE;
			end
			default: begin
				state_d = ctud_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		byte_ch.ready = 1'b0;
		run_valid     = 1'b0;
		ram_we        = 1'b0;
		run_done      = 1'b0;
		case (state_q)
			ctud_pkg::ST_IDLE: begin
				byte_ch.ready = 1'b1;
			end
			ctud_pkg::ST_RUN: begin
				run_valid = fit;
				run_done  = !fit || run_ready;
			end
			ctud_pkg::ST_TWR: begin
				ram_we = twr_ok_q;
			end
			default: begin
			end
		endcase
	end

	assign ram_re    = tw_acc ? tw_ok : (conv_acc && dec_lookup);
	assign ram_raddr = byte_ch.command
	                 ? ctud_pkg::row_addr(byte_ch.table_map, byte_ch.table_code)
	                 : ctud_pkg::row_addr(sel, dec_code);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ctud_pkg::ST_IDLE;
			esc_q           <= ctud_pkg::ESC_NORMAL;
			bytes_written_q <= '0;
			halted_q        <= 1'b0;
			map_select_q    <= '0;
			cap_q           <= ctud_pkg::CAP_RESET;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					ctud_pkg::CFG_MAP_SELECT:   map_select_q <= cfg_data[ctud_pkg::MAP_W-1:0];
					ctud_pkg::CFG_OUT_CAPACITY: cap_q        <= cfg_data;
					default: begin
					end
				endcase
			end
			if (conv_acc) begin
				if (byte_ch.last_byte && !(dec_lookup || dec_lit)) begin
					// item done on accept: end of buffer clears now
					esc_q           <= ctud_pkg::ESC_NORMAL;
					bytes_written_q <= '0;
					halted_q        <= 1'b0;
				end else begin
					esc_q <= dec_esc_next;
					if (dec_halt)
						halted_q <= 1'b1;
				end
			end
			if (run_done) begin
				if (last_q) begin
					esc_q           <= ctud_pkg::ESC_NORMAL;
					bytes_written_q <= '0;
					halted_q        <= 1'b0;
				end else if (fit) begin
					bytes_written_q <= bytes_written_q + ctud_pkg::CNT_W'(run_len);
				end else begin
					halted_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (conv_acc) begin
			lit_q      <= dec_lit;
			lit_byte_q <= dec_lit_byte;
			last_q     <= byte_ch.last_byte;
		end
		if (tw_acc) begin
			twr_row_q  <= ctud_pkg::row_addr(byte_ch.table_map, byte_ch.table_code);
			twr_pos_q  <= byte_ch.table_pos;
			twr_data_q <= byte_ch.data_byte;
			twr_ok_q   <= tw_ok;
		end
	end

	ctud_ram #(
		.WIDTH (ctud_pkg::ENTRY_W),
		.DEPTH (ctud_pkg::ROWS)
	) u_map_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (twr_row_q),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	ctud_emit u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.run       (run),
		.run_ready (run_ready),
		.utf8_ch   (utf8_ch)
	);

	`CTUD_ASSERT(a_run_nonempty, run.valid, run.len != '0, "empty run handed to output")
	`CTUD_ASSERT(a_no_run_halted, halted_q, !run.valid, "run handed off while halted")
	`CTUD_ASSERT(a_wr_after_req, ram_we, $past(tw_acc), "row write without table command")
	`CTUD_ASSERT_NEXT(a_esc_close,
		conv_acc && !halted_q && esc_q == ctud_pkg::ESC_PENDING,
		esc_q == ctud_pkg::ESC_CLOSE && state_q == ctud_pkg::ST_RUN,
		"escaped byte did not start a lookup")

endmodule

`default_nettype wire

// ===== dv/charset_table_to_utf8_decoder_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// charset_table_to_utf8_decoder_tb
// Self-checking bench for the device charset to UTF-8 decoder. Entries are
// loaded by table-write transfers before any conversion can read them. A
// predictor follows every accepted transfer and queues the UTF-8 bytes it
// should cause; each output transfer is checked against the oldest one.
// ----------------------------------------------------------------------------

module charset_table_to_utf8_decoder_tb;

	import ctud_pkg::*;

	localparam int CYCLE_LIMIT   = 800_000;
	localparam int SETTLE_CYCLES = 8;
	localparam int NO_CODE       = -1;
	localparam int ESC_CODE      = -2;

	typedef struct {
		bit          command;
		logic [7:0]  data;
		bit          last;
		logic [1:0]  tmap;
		logic [7:0]  tcode;
		logic [3:0]  tpos;
	} dev_item_t;

	typedef struct {
		logic [7:0] ch;
		bit         eor;
	} utf8_byte_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CNT_W-1:0]     cfg_data;

	ctud_byte_if byte_ch ();
	ctud_utf8_if utf8_ch ();

	charset_table_to_utf8_decoder u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.byte_ch   (byte_ch),
		.utf8_ch   (utf8_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// predictor state
	logic [7:0]  tbl_bytes [NUM_MAPS][NUM_CODES][ENTRY_BYTES];
	bit          tbl_known [NUM_MAPS][NUM_CODES][ENTRY_BYTES];
	logic [1:0]  sel_map     = 2'd0;
	int unsigned capacity    = CAP_RESET;
	esc_t        esc_state   = ESC_NORMAL;
	int unsigned run_count   = 0;
	bit          out_halted  = 1'b0;
	logic [7:0]  run_bytes[$];
	utf8_byte_t  utf8_expected[$];

	int src_idle_pct  = 31;
	int sink_idle_pct = 87;
	int hold_left     = 0;
	int error_count   = 0;
	int cycle_count   = 0;
	int items_sent    = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("charset_table_to_utf8_decoder verification failed");
		$finish;
	end

	// ------------------------------------------------------------------
	// prediction
	// ------------------------------------------------------------------

	// what a normal-mode byte turns into before the direct/table decision
	function automatic int mapped_code(input logic [7:0] b);
		case (b)
			DEV_DROP_A4, DEV_DROP_A7, DEV_DROP_8F: return NO_CODE;
			DEV_CR:                                return int'(CH_LF);
			DEV_SPACE_81, DEV_SPACE_A1:            return int'(CH_SPACE);
			DEV_TAB_8D, DEV_TAB_A3:                return int'(CH_TAB);
			DEV_HYPHEN_AD:                         return int'(CH_HYPHEN);
			DEV_ESC:                               return ESC_CODE;
			default: return (b >= DEV_CTRL_LO && b <= DEV_CTRL_HI) ? NO_CODE : int'(b);
		endcase
	endfunction

	function automatic int entry_length(input int m, input int c);
		int n;
		n = 0;
		while (n < ENTRY_BYTES - 1 && tbl_bytes[m][c][n] != 8'h00)
			n++;
		return n;
	endfunction

	task automatic emit_run(input logic [7:0] run_in[$]);
		if (run_count + run_in.size() >= capacity) begin
			out_halted = 1'b1;
		end else begin
			foreach (run_in[i])
				run_bytes.push_back(run_in[i]);
			run_count += run_in.size();
		end
	endtask

	task automatic emit_code(input logic [7:0] code, input bit escaped);
		logic [7:0] one[$];
		int         m;
		int         n;
		if (!escaped && (code == CH_TAB || code == CH_LF || code == DEV_CR)) begin
			one.push_back(code);
			emit_run(one);
			return;
		end
		m = (sel_map < NUM_MAPS) ? sel_map : 0;
		n = entry_length(m, code);
		if (n == 0)
			one.push_back(CH_QMARK);
		for (int i = 0; i < n; i++)
			one.push_back(tbl_bytes[m][code][i]);
		emit_run(one);
	endtask

	task automatic convert_normal(input logic [7:0] b);
		int t;
		if (run_count + 1 >= capacity) begin
			out_halted = 1'b1;
			return;
		end
		t = mapped_code(b);
		if (t == ESC_CODE)
			esc_state = ESC_PENDING;
		else if (t != NO_CODE)
			emit_code(8'(t), 1'b0);
	endtask

	task automatic predict_utf8(input dev_item_t it);
		esc_t mode;
		run_bytes.delete();
		if (it.command) begin
			if (it.tmap < NUM_MAPS && it.tpos < ENTRY_BYTES) begin
				tbl_bytes[it.tmap][it.tcode][it.tpos] = it.data;
				tbl_known[it.tmap][it.tcode][it.tpos] = 1'b1;
			end
			return;
		end
		if (!out_halted) begin
			mode      = esc_state;
			esc_state = ESC_NORMAL;
			if (mode == ESC_PENDING) begin
				emit_code(it.data, 1'b1);
				esc_state = ESC_CLOSE;
			end else if (!(mode == ESC_CLOSE && it.data == DEV_ESC)) begin
				convert_normal(it.data);
			end
		end
		if (it.last) begin
			esc_state  = ESC_NORMAL;
			run_count  = 0;
			out_halted = 1'b0;
		end
		foreach (run_bytes[i])
			utf8_expected.push_back('{run_bytes[i], i == run_bytes.size() - 1});
	endtask

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------

	// entry can be read without touching a byte never loaded
	function automatic bit entry_safe(input int m, input int c);
		for (int i = 0; i < ENTRY_BYTES - 1; i++) begin
			if (!tbl_known[m][c][i])
				return 1'b0;
			if (tbl_bytes[m][c][i] == 8'h00)
				return 1'b1;
		end
		return 1'b1;
	endfunction

	// table entry a conversion of b may read; halting is ignored on purpose
	function automatic int code_to_read(input logic [7:0] b);
		int t;
		if (esc_state == ESC_PENDING)
			return int'(b);
		if (esc_state == ESC_CLOSE && b == DEV_ESC)
			return NO_CODE;
		t = mapped_code(b);
		if (t < 0 || t == int'(CH_TAB) || t == int'(CH_LF) || t == int'(DEV_CR))
			return NO_CODE;
		return t;
	endfunction

	task automatic send_item(input dev_item_t it);
		if ($urandom_range(99) < src_idle_pct) begin
			byte_ch.valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < src_idle_pct);
		end
		byte_ch.valid      <= 1'b1;
		byte_ch.command    <= it.command;
		byte_ch.data_byte  <= it.data;
		byte_ch.last_byte  <= it.last;
		byte_ch.table_map  <= it.tmap;
		byte_ch.table_code <= it.tcode;
		byte_ch.table_pos  <= it.tpos;
		@(posedge clk);
		while (byte_ch.ready !== 1'b1)
			@(posedge clk);
		items_sent++;
		predict_utf8(it);
	endtask

	task automatic load_entry(input int m, input int c, input int len);
		for (int i = 0; i < len; i++)
			send_item('{1'b1, 8'($urandom_range(1, 255)), 1'($urandom), 2'(m), 8'(c), 4'(i)});
		if (len < ENTRY_BYTES - 1)
			send_item('{1'b1, 8'h00, 1'($urandom), 2'(m), 8'(c), 4'(len)});
	endtask

	function automatic int pick_len();
		return ($urandom_range(99) < 10) ? $urandom_range(4, ENTRY_BYTES - 1)
		                                 : $urandom_range(0, 3);
	endfunction

	task automatic convert(input logic [7:0] b, input bit last);
		int c;
		int m;
		c = code_to_read(b);
		m = (sel_map < NUM_MAPS) ? sel_map : 0;
		if (c >= 0 && !entry_safe(m, c))
			load_entry(m, c, pick_len());
		send_item('{1'b0, b, last, 2'($urandom), 8'($urandom), 4'($urandom)});
	endtask

	task automatic wait_idle();
		byte_ch.valid <= 1'b0;
		while (utf8_expected.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// only called while the block is idle
	task automatic write_config(input int m, input int unsigned cap);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_MAP_SELECT;
		cfg_data  <= CNT_W'(m);
		@(posedge clk);
		cfg_index <= CFG_OUT_CAPACITY;
		cfg_data  <= CNT_W'(cap);
		@(posedge clk);
		cfg_we    <= 1'b0;
		sel_map   = 2'(m);
		capacity  = cap & 32'h1ffff;
	endtask

	// ------------------------------------------------------------------
	// output side: ready pattern and checking
	// ------------------------------------------------------------------
	initial begin
		utf8_byte_t want;
		utf8_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && utf8_ch.valid === 1'b1 && utf8_ch.ready === 1'b1) begin
				if (utf8_expected.size() == 0) begin
					$error("unexpected output transfer: out_byte %h end_of_run %b",
					       utf8_ch.out_byte, utf8_ch.end_of_run);
					error_count++;
				end else begin
					want = utf8_expected.pop_front();
					if (utf8_ch.out_byte !== want.ch) begin
						$error("out_byte: expected %h, actual %h", want.ch, utf8_ch.out_byte);
						error_count++;
					end
					if (utf8_ch.end_of_run !== want.eor) begin
						$error("end_of_run: expected %b, actual %b", want.eor,
						       utf8_ch.end_of_run);
						error_count++;
					end
				end
			end
			if (hold_left > 0) begin
				hold_left--;
				utf8_ch.ready <= 1'b0;
			end else begin
				utf8_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------

	task automatic test_directed_codes();
		logic [7:0] codes[$] = '{8'h00, 8'hff, 8'h41, DEV_CR, CH_LF, CH_TAB, DEV_SPACE_81,
		                         DEV_SPACE_A1, DEV_TAB_8D, DEV_TAB_A3, DEV_HYPHEN_AD,
		                         DEV_DROP_A4, DEV_DROP_A7, DEV_DROP_8F, DEV_CTRL_HI,
		                         8'ha2, 8'h7f, 8'h80};
		write_config(0, CAP_RESET);
		load_entry(0, 8'h00, 0);
		load_entry(0, 8'hff, ENTRY_BYTES - 1);
		foreach (codes[i])
			convert(codes[i], 1'b0);
		convert(8'h41, 1'b1);
	endtask

	task automatic test_escape_sequences();
		logic [7:0] seq[$] = '{DEV_ESC, CH_TAB, DEV_ESC, DEV_ESC, DEV_CR, 8'h5a,
		                       DEV_ESC, DEV_DROP_A4, DEV_ESC, DEV_ESC, DEV_ESC};
		foreach (seq[i])
			convert(seq[i], 1'b0);
		// closing escape swallowed on the buffer's last byte
		convert(DEV_ESC, 1'b1);
		convert(8'h41, 1'b1);
	endtask

	task automatic test_table_write_range();
		send_item('{1'b1, 8'h55, 1'b0, 2'd3, 8'h41, 4'd0});
		send_item('{1'b1, 8'haa, 1'b1, 2'd0, 8'h41, 4'd15});
		convert(8'h41, 1'b0);
		send_item('{1'b1, 8'h00, 1'b0, 2'd0, 8'h41, 4'd0});
		convert(8'h41, 1'b1);
	endtask

	task automatic test_capacity_limits();
		int unsigned caps[$] = '{1, 2, 3, 5, 65536};
		foreach (caps[i]) begin
			wait_idle();
			write_config(0, caps[i]);
			convert(8'h41, 1'b0);
			convert(8'h42, 1'b0);
			convert(8'hff, 1'b0);
			convert(DEV_CR, 1'b0);
			convert(8'h43, 1'b1);
			convert(8'h41, 1'b1);
		end
	endtask

	task automatic test_map_select();
		for (int m = 0; m < NUM_MAPS; m++) begin
			wait_idle();
			write_config(m, CAP_RESET);
			for (int c = 8'h41; c <= 8'h43; c++)
				convert(8'(c), 1'b0);
			convert(DEV_SPACE_81, 1'b0);
			convert(DEV_HYPHEN_AD, 1'b1);
		end
	endtask

	task automatic test_output_backpressure();
		wait_idle();
		write_config(0, 65536);
		src_idle_pct = 0;
		hold_left    = 400;
		for (int k = 0; k < 6; k++)
			convert(8'h41 + 8'(k % 3), k == 5);
		src_idle_pct = 31;
	endtask

	task automatic test_random_traffic();
		logic [7:0] specials[$] = '{DEV_CR, CH_LF, CH_TAB, DEV_SPACE_81, DEV_SPACE_A1,
		                            DEV_TAB_8D, DEV_TAB_A3, DEV_HYPHEN_AD, DEV_DROP_A4,
		                            DEV_DROP_A7, DEV_DROP_8F, DEV_ESC, DEV_CTRL_HI};
		int src_pct[3]  = '{31, 87, 0};
		int sink_pct[3] = '{87, 31, 0};
		int          start;
		int          r;
		int unsigned cap;
		for (int p = 0; p < 3; p++) begin
			wait_idle();
			r = $urandom_range(99);
			if (r < 50)
				cap = $urandom_range(2, 40);
			else if (r < 75)
				cap = $urandom_range(4096, 65536);
			else
				cap = $urandom_range(1, 65536);
			write_config($urandom_range(NUM_MAPS - 1), cap);
			src_idle_pct  = src_pct[p];
			sink_idle_pct = sink_pct[p];
			start = items_sent;
			// table loads count toward the phase budget
			while (items_sent - start < 18) begin
				r = $urandom_range(99);
				if (r < 55) begin
					convert(8'($urandom), $urandom_range(15) == 0);
				end else if (r < 75) begin
					convert(specials[$urandom_range(specials.size() - 1)],
					        $urandom_range(15) == 0);
				end else if (r < 87) begin
					// escape, escaped byte, usually a closing escape
					convert(DEV_ESC, 1'b0);
					convert(8'($urandom), 1'b0);
					if ($urandom_range(3) != 0)
						convert(DEV_ESC, $urandom_range(7) == 0);
				end else if (r < 95) begin
					send_item('{1'b1, 8'($urandom), 1'($urandom), 2'($urandom),
					            8'($urandom), 4'($urandom)});
				end else begin
					convert(8'($urandom), 1'b1);
				end
			end
		end
	endtask

	initial begin
		arst_n             <= 1'b0;
		cfg_we             <= 1'b0;
		cfg_index          <= CFG_MAP_SELECT;
		cfg_data           <= '0;
		byte_ch.valid      <= 1'b0;
		byte_ch.command    <= 1'b0;
		byte_ch.data_byte  <= 8'h00;
		byte_ch.last_byte  <= 1'b0;
		byte_ch.table_map  <= '0;
		byte_ch.table_code <= '0;
		byte_ch.table_pos  <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_codes();
		test_escape_sequences();
		test_table_write_range();
		test_capacity_limits();
		test_map_select();
		test_output_backpressure();
		test_random_traffic();

		wait_idle();
		if (error_count == 0)
			$display("charset_table_to_utf8_decoder verification clean");
		else
			$display("charset_table_to_utf8_decoder verification failed");
		$finish;
	end

endmodule
